FILE: rtl/llwd_pkg.sv
`default_nettype none

package llwd_pkg;

  localparam int unsigned IdentW = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned LoadW  = 7;
  // Score is active*10 + load; 255*10 + 127 fits in 12 bits.
  localparam int unsigned ScoreW = 12;

  typedef enum logic {
    FUNC_UPDATE   = 1'b0,
    FUNC_DISPATCH = 1'b1
  } func_e;

  // Data written into one slot by an update.
  typedef struct packed {
    logic [IdentW-1:0] ident;
    logic              running;
    logic [CountW-1:0] active;
    logic [CountW-1:0] capacity;
    logic [LoadW-1:0]  load;
  } slot_wr_t;

  // Best candidate so far, handed from cell to cell during a scan.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [ScoreW-1:0] score;
    logic [IdentW-1:0] ident;
    logic [CountW-1:0] active;
  } cand_t;

endpackage

`default_nettype wire

FILE: rtl/llwd_cell.sv
`default_nettype none

module llwd_cell #(
  parameter int unsigned IDXW     = 4,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire  [llwd_pkg::IdentW-1:0]      pin_i,
  input  wire                              wr_en_i,
  input  wire  llwd_pkg::slot_wr_t         wr_i,
  input  wire                              inc_en_i,
  input  wire  llwd_pkg::cand_t            cand_i,
  input  wire  [IDXW-1:0]                  cand_idx_i,
  output llwd_pkg::cand_t                  cand_o,
  output logic [IDXW-1:0]                  cand_idx_o
);

  logic                            used_q;
  logic [llwd_pkg::IdentW-1:0]     ident_q;
  logic                            running_q;
  logic [llwd_pkg::CountW-1:0]     active_q;
  logic [llwd_pkg::CountW-1:0]     capacity_q;
  logic [llwd_pkg::LoadW-1:0]      load_q;

  logic                            eligible;
  logic [llwd_pkg::ScoreW-1:0]     score;
  logic                            take;
  llwd_pkg::cand_t                 cand_d;
  logic [IDXW-1:0]                 cand_idx_d;

  // active*10 as active*8 + active*2.
  assign score = ({{(llwd_pkg::ScoreW-llwd_pkg::CountW-3){1'b0}}, active_q, 3'b000})
               + ({{(llwd_pkg::ScoreW-llwd_pkg::CountW-1){1'b0}}, active_q, 1'b0})
               + {{(llwd_pkg::ScoreW-llwd_pkg::LoadW){1'b0}}, load_q};

  assign eligible = used_q && running_q && (active_q < capacity_q)
                 && ((pin_i == '0) || (pin_i == ident_q));

  // Strict less-than: an earlier (lower) slot keeps a tie.
  assign take = eligible && (!cand_i.found || (score < cand_i.score));

  always_comb begin
    cand_d     = cand_i;
    cand_idx_d = cand_idx_i;
    if (take) begin
      cand_d.found  = 1'b1;
      cand_d.score  = score;
      cand_d.ident  = ident_q;
      cand_d.active = active_q;
      cand_idx_d    = IDXW'(CELL_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= 1'b0;
      ident_q    <= '0;
      running_q  <= 1'b0;
      active_q   <= '0;
      capacity_q <= '0;
      load_q     <= '0;
      cand_o     <= '0;
      cand_idx_o <= '0;
    end else begin
      if (wr_en_i) begin
        used_q     <= 1'b1;
        ident_q    <= wr_i.ident;
        running_q  <= wr_i.running;
        active_q   <= wr_i.active;
        capacity_q <= wr_i.capacity;
        load_q     <= wr_i.load;
      end else if (inc_en_i) begin
        active_q <= active_q + llwd_pkg::CountW'(1);
      end
      cand_o     <= cand_d;
      cand_idx_o <= cand_idx_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/least_loaded_worker_dispatch.sv
`default_nettype none

// Least-loaded worker dispatch. The block holds a table of WORKER_SLOTS worker
// slots, one per cell in a row of cells. An item is taken at a rising edge
// where start is high and busy is low. An update item (func 0) writes the slot
// named by slot_i in that same edge; its all-zero result appears on the result
// ports in the next cycle, marked by done_o, and busy never rises for it. A
// dispatch item (func 1) launches a candidate record into the first cell; the
// record moves one cell per cycle, and each cell replaces it when its own slot
// is eligible and scores strictly lower (score is active*10 + load), so ties
// go to the lowest slot. When the record leaves the last cell, the winner's
// active count is incremented and the result is shown for one cycle with
// done_o. The scan through the chain sets the pace: a dispatch result appears
// once the record has passed the launch register and every cell register, and
// the next item can be taken in the cycle of that result, so the block takes
// no new item while a dispatch is in flight. The receiver cannot stall: every
// result is a one-cycle strobe and must be captured when done_o is high.

module least_loaded_worker_dispatch #(
  parameter int unsigned WORKER_SLOTS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [0:0]  func_i,
  input  wire  [3:0]  slot_i,
  input  wire  [15:0] worker_ident_i,
  input  wire  [0:0]  worker_running_i,
  input  wire  [7:0]  active_tasks_i,
  input  wire  [7:0]  task_capacity_i,
  input  wire  [6:0]  cpu_load_i,
  input  wire  [15:0] pinned_worker_i,
  output logic        done_o,
  output logic [0:0]  granted_o,
  output logic [3:0]  chosen_slot_o,
  output logic [15:0] chosen_ident_o,
  output logic [7:0]  active_after_o
);

  localparam int unsigned IDXW = (WORKER_SLOTS > 1) ? $clog2(WORKER_SLOTS) : 1;

  logic                        busy_q;
  logic                        launch_q;
  logic [15:0]                 pin_q;
  logic                        done_q;
  logic                        granted_q;
  logic [3:0]                  chosen_slot_q;
  logic [15:0]                 chosen_ident_q;
  logic [7:0]                  active_after_q;

  logic                        accept;
  logic                        upd_accept;
  logic                        disp_accept;
  llwd_pkg::slot_wr_t          wr_data;
  logic [WORKER_SLOTS-1:0]     wr_en;
  logic [WORKER_SLOTS-1:0]     inc_en;

  // The candidate chain: entry 0 feeds the first cell, entry WORKER_SLOTS
  // is the output of the last cell.
  llwd_pkg::cand_t             cand   [WORKER_SLOTS+1];
  logic [IDXW-1:0]             cand_idx [WORKER_SLOTS+1];
  llwd_pkg::cand_t             fin;
  logic [IDXW-1:0]             fin_idx;
  logic [IDXW+3:0]             fin_idx_ext;

  assign accept      = start && !busy_q;
  assign upd_accept  = accept && (func_i == llwd_pkg::FUNC_UPDATE);
  assign disp_accept = accept && (func_i == llwd_pkg::FUNC_DISPATCH);

  assign wr_data.ident    = worker_ident_i;
  assign wr_data.running  = worker_running_i[0];
  assign wr_data.active   = active_tasks_i;
  assign wr_data.capacity = task_capacity_i;
  assign wr_data.load     = cpu_load_i;

  // A fresh, empty candidate enters the first cell in the cycle after the
  // dispatch transfer, while the pin is held in pin_q for the whole scan.
  always_comb begin
    cand[0]       = '0;
    cand[0].valid = launch_q;
    cand_idx[0]   = '0;
  end

  assign fin         = cand[WORKER_SLOTS];
  assign fin_idx     = cand_idx[WORKER_SLOTS];
  assign fin_idx_ext = {4'b0000, fin_idx};

  for (genvar k = 0; k < WORKER_SLOTS; k++) begin : g_cell
    // Slots at or beyond the table size never match, so such updates are dropped.
    assign wr_en[k]  = upd_accept && ({2'b00, slot_i} == 6'(k));
    assign inc_en[k] = fin.valid && fin.found && (fin_idx == IDXW'(k));

    llwd_cell #(
      .IDXW     (IDXW),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .pin_i      (pin_q),
      .wr_en_i    (wr_en[k]),
      .wr_i       (wr_data),
      .inc_en_i   (inc_en[k]),
      .cand_i     (cand[k]),
      .cand_idx_i (cand_idx[k]),
      .cand_o     (cand[k+1]),
      .cand_idx_o (cand_idx[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      launch_q       <= 1'b0;
      pin_q          <= '0;
      done_q         <= 1'b0;
      granted_q      <= 1'b0;
      chosen_slot_q  <= '0;
      chosen_ident_q <= '0;
      active_after_q <= '0;
    end else begin
      done_q   <= 1'b0;
      launch_q <= 1'b0;
      if (disp_accept) begin
        busy_q   <= 1'b1;
        launch_q <= 1'b1;
        pin_q    <= pinned_worker_i;
      end else if (upd_accept) begin
        done_q         <= 1'b1;
        granted_q      <= 1'b0;
        chosen_slot_q  <= '0;
        chosen_ident_q <= '0;
        active_after_q <= '0;
      end
      // The scan record leaves the last cell: report and release.
      if (fin.valid) begin
        busy_q         <= 1'b0;
        done_q         <= 1'b1;
        granted_q      <= fin.found;
        chosen_slot_q  <= fin.found ? fin_idx_ext[3:0] : 4'd0;
        chosen_ident_q <= fin.found ? fin.ident : 16'd0;
        active_after_q <= fin.found ? (fin.active + 8'd1) : 8'd0;
      end
    end
  end

  assign busy           = busy_q;
  assign done_o         = done_q;
  assign granted_o      = granted_q;
  assign chosen_slot_o  = chosen_slot_q;
  assign chosen_ident_o = chosen_ident_q;
  assign active_after_o = active_after_q;

  // A scan record only reaches the end of the chain during a dispatch.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fin.valid |-> busy_q)
    else $error("scan finished while not busy");

  // At most one slot's active count is incremented per scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(inc_en))
    else $error("more than one slot incremented");

  // A dispatch transfer launches a scan in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) disp_accept |=> launch_q && busy_q)
    else $error("dispatch did not launch a scan");

  // A granted result always reports a nonzero count after increment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_o && granted_o[0]) |-> (active_after_o != 8'd0))
    else $error("grant with zero count");

endmodule

`default_nettype wire

FILE: bench/tb_least_loaded_worker_dispatch.sv
module tb_least_loaded_worker_dispatch;
  timeunit 1ns;
  timeprecision 1ps;

  // Table size of the instance under test and the weight that turns the
  // active count into part of the score (active*10 + load).
  localparam int unsigned SLOTS        = 16;
  localparam int unsigned LOAD_WEIGHT  = 10;
  localparam int unsigned RESET_CYCLES = 7;
  // A dispatch result shows up once its record has passed the whole chain, so
  // waiting beyond a full scan covers everything the block can have in flight.
  localparam int unsigned DRAIN_CYCLES = SLOTS + 4;
  // The slowest correct run is about 1850 items, each waiting out a full scan
  // plus the longest idle burst, which stays far below CYCLE_LIMIT.
  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned MAX_REPORTS  = 10;

  // One input item, one field per port.
  typedef struct packed {
    llwd_pkg::func_e             func;
    logic [3:0]                  slot;
    logic [llwd_pkg::IdentW-1:0] ident;
    logic                        running;
    logic [llwd_pkg::CountW-1:0] active;
    logic [llwd_pkg::CountW-1:0] capacity;
    logic [llwd_pkg::LoadW-1:0]  load;
    logic [llwd_pkg::IdentW-1:0] pin;
  } work_req_t;

  // One result: the grant a dispatch produced, or all zero for an update.
  typedef struct packed {
    logic                        granted;
    logic [3:0]                  slot;
    logic [llwd_pkg::IdentW-1:0] ident;
    logic [llwd_pkg::CountW-1:0] active_after;
  } grant_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [0:0]        func_i;
  logic [3:0]        slot_i;
  logic [15:0]       worker_ident_i;
  logic [0:0]        worker_running_i;
  logic [7:0]        active_tasks_i;
  logic [7:0]        task_capacity_i;
  logic [6:0]        cpu_load_i;
  logic [15:0]       pinned_worker_i;
  logic              done_o;
  logic [0:0]        granted_o;
  logic [3:0]        chosen_slot_o;
  logic [15:0]       chosen_ident_o;
  logic [7:0]        active_after_o;

  // Shadow copy of the worker table, updated in transfer order.
  logic                        tbl_used     [SLOTS];
  logic [llwd_pkg::IdentW-1:0] tbl_ident    [SLOTS];
  logic                        tbl_running  [SLOTS];
  logic [llwd_pkg::CountW-1:0] tbl_active   [SLOTS];
  logic [llwd_pkg::CountW-1:0] tbl_capacity [SLOTS];
  logic [llwd_pkg::LoadW-1:0]  tbl_load     [SLOTS];

  // Grants predicted at each transfer and not yet seen on the result ports.
  grant_t            pending_grants [$];
  grant_t            want_grant;

  // A small set of worker ids so that pinned dispatches actually hit a
  // worker most of the time; the zero id and both extremes are among them.
  logic [llwd_pkg::IdentW-1:0] ident_pool [8] = '{16'h0000, 16'h0001, 16'h00A5,
                                                  16'h1234, 16'h7FFF, 16'h8000,
                                                  16'hC3C3, 16'hFFFF};

  int unsigned       failures    = 0;
  int unsigned       cycle_count = 0;
  bit                idle_on     = 1'b0;

  least_loaded_worker_dispatch #(
    .WORKER_SLOTS(SLOTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .slot_i          (slot_i),
    .worker_ident_i  (worker_ident_i),
    .worker_running_i(worker_running_i),
    .active_tasks_i  (active_tasks_i),
    .task_capacity_i (task_capacity_i),
    .cpu_load_i      (cpu_load_i),
    .pinned_worker_i (pinned_worker_i),
    .done_o          (done_o),
    .granted_o       (granted_o),
    .chosen_slot_o   (chosen_slot_o),
    .chosen_ident_o  (chosen_ident_o),
    .active_after_o  (active_after_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog. A hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_grants.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Applies one item to the shadow table and returns the grant it causes.
  // An update overwrites its slot and marks it used. A dispatch picks the
  // eligible slot with the least score; the strict compare keeps the lowest
  // slot on a tie. A slot is eligible when it is used, running, below its
  // capacity, and the pin is either "any" (zero) or equal to its id. A worker
  // whose id is zero can therefore only be reached by an unpinned dispatch.
  function automatic grant_t apply_request(input work_req_t r);
    grant_t                      g;
    logic                        found;
    int unsigned                 pick;
    logic [llwd_pkg::ScoreW-1:0] best_score;
    logic [llwd_pkg::ScoreW-1:0] score;
    g          = '0;
    found      = 1'b0;
    pick       = 0;
    best_score = '0;
    if (r.func == llwd_pkg::FUNC_UPDATE) begin
      if (r.slot < SLOTS) begin
        tbl_used[r.slot]     = 1'b1;
        tbl_ident[r.slot]    = r.ident;
        tbl_running[r.slot]  = r.running;
        tbl_active[r.slot]   = r.active;
        tbl_capacity[r.slot] = r.capacity;
        tbl_load[r.slot]     = r.load;
      end
      return g;
    end
    for (int k = 0; k < SLOTS; k++) begin
      if (tbl_used[k] && tbl_running[k] && tbl_active[k] < tbl_capacity[k] &&
          (r.pin == '0 || r.pin == tbl_ident[k])) begin
        score = llwd_pkg::ScoreW'(tbl_active[k]) * llwd_pkg::ScoreW'(LOAD_WEIGHT)
              + llwd_pkg::ScoreW'(tbl_load[k]);
        if (!found || score < best_score) begin
          found      = 1'b1;
          pick       = k;
          best_score = score;
        end
      end
    end
    // No eligible worker: the result is all zero and the table is untouched.
    // Below capacity means the increment can never wrap past 255.
    if (found) begin
      tbl_active[pick] = tbl_active[pick] + 1'b1;
      g.granted        = 1'b1;
      g.slot           = 4'(pick);
      g.ident          = tbl_ident[pick];
      g.active_after   = tbl_active[pick];
    end
    return g;
  endfunction

  task automatic note_failure(input string what);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("cycle %0d: %s", cycle_count, what);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      note_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    end
  endtask

  // Result checker. done_o is sampled at the rising edge that ends the result
  // cycle, which is the edge at which the transfer of that result happens.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_grants.size() == 0) begin
        note_failure("result with no item waiting for it");
      end else begin
        want_grant = pending_grants.pop_front();
        check_field("granted", 16'(granted_o), 16'(want_grant.granted));
        check_field("chosen_slot", 16'(chosen_slot_o), 16'(want_grant.slot));
        check_field("chosen_ident", chosen_ident_o, want_grant.ident);
        check_field("active_after", 16'(active_after_o), 16'(want_grant.active_after));
      end
    end
  end

  // Presents one item from a falling edge on and holds it until the block
  // takes it: a rising edge with start high and busy low. The expected grant
  // is worked out right at that edge, so the shadow table sees items in the
  // same order as the block. The task returns at the next falling edge with
  // start still high, so back-to-back items keep start up without a glitch.
  task automatic send_item(input work_req_t r);
    start            = 1'b1;
    func_i           = r.func;
    slot_i           = r.slot;
    worker_ident_i   = r.ident;
    worker_running_i = r.running;
    active_tasks_i   = r.active;
    task_capacity_i  = r.capacity;
    cpu_load_i       = r.load;
    pinned_worker_i  = r.pin;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_grants = {pending_grants, apply_request(r)};
    @(negedge clk_i);
  endtask

  // Lowers start and waits. The payload ports carry junk meanwhile, which the
  // block must ignore since no transfer happens.
  task automatic idle_cycles(input int unsigned n);
    start            = 1'b0;
    func_i           = 1'($urandom);
    slot_i           = 4'($urandom);
    worker_ident_i   = 16'($urandom);
    worker_running_i = 1'($urandom);
    active_tasks_i   = 8'($urandom);
    task_capacity_i  = 8'($urandom);
    cpu_load_i       = 7'($urandom);
    pinned_worker_i  = 16'($urandom);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      idle_cycles($urandom_range(1, 18));
    end
  endtask

  // Stops sending and waits until every predicted result has come back, then
  // a little longer so nothing is still in flight.
  task automatic wait_drain();
    start = 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic work_req_t make_update(input logic [3:0] slot,
                                            input logic [llwd_pkg::IdentW-1:0] ident,
                                            input logic running,
                                            input logic [llwd_pkg::CountW-1:0] active,
                                            input logic [llwd_pkg::CountW-1:0] capacity,
                                            input logic [llwd_pkg::LoadW-1:0] load);
    work_req_t r;
    r          = '0;
    r.func     = llwd_pkg::FUNC_UPDATE;
    r.slot     = slot;
    r.ident    = ident;
    r.running  = running;
    r.active   = active;
    r.capacity = capacity;
    r.load     = load;
    return r;
  endfunction

  function automatic work_req_t make_dispatch(input logic [llwd_pkg::IdentW-1:0] pin);
    work_req_t r;
    r      = '0;
    r.func = llwd_pkg::FUNC_DISPATCH;
    r.pin  = pin;
    return r;
  endfunction

  // Random update. Most slots get small active counts with room to spare so
  // that dispatches keep finding workers; some get the full 8-bit range or
  // counts close to 255, and some loads go above 100, which is stored as is.
  function automatic work_req_t random_update();
    work_req_t r;
    r         = '0;
    r.func    = llwd_pkg::FUNC_UPDATE;
    r.slot    = 4'($urandom_range(0, SLOTS - 1));
    r.ident   = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                             : ident_pool[$urandom_range(0, 7)];
    r.running = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 9))
      0: begin
        r.active   = 8'($urandom);
        r.capacity = 8'($urandom);
      end
      1: begin
        r.active   = 8'($urandom_range(240, 255));
        r.capacity = 8'($urandom_range(240, 255));
      end
      default: begin
        r.active   = 8'($urandom_range(0, 12));
        r.capacity = r.active + 8'($urandom_range(0, 20));
      end
    endcase
    r.load = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100));
    r.pin  = 16'($urandom);
    return r;
  endfunction

  // Random dispatch. The update fields carry noise, which must not matter.
  // The pin is "any" for a good share, a pool id for most of the rest, and
  // now and then a random id that is unlikely to match anything.
  function automatic work_req_t random_dispatch();
    work_req_t r;
    int unsigned pick;
    r          = '0;
    r.func     = llwd_pkg::FUNC_DISPATCH;
    r.slot     = 4'($urandom);
    r.ident    = 16'($urandom);
    r.running  = 1'($urandom);
    r.active   = 8'($urandom);
    r.capacity = 8'($urandom);
    r.load     = 7'($urandom);
    pick       = $urandom_range(0, 9);
    if (pick < 4) begin
      r.pin = '0;
    end else if (pick < 8) begin
      r.pin = ident_pool[$urandom_range(0, 7)];
    end else begin
      r.pin = 16'($urandom);
    end
    return r;
  endfunction

  // A dispatch on an empty table finds nobody, pinned or not.
  task automatic test_empty_table();
    send_item(make_dispatch(16'h0000));
    send_item(make_dispatch(16'hFFFF));
  endtask

  // Top of every field: the highest slot, the all-ones id, a load of 127
  // that lies above 100, and an active count that reaches 255 on the grant
  // and then sits at capacity. A stopped worker is never picked.
  task automatic test_field_extremes();
    send_item(make_update(4'd15, 16'hFFFF, 1'b1, 8'd254, 8'd255, 7'd127));
    send_item(make_dispatch(16'hFFFF));
    send_item(make_dispatch(16'hFFFF));
    send_item(make_update(4'd0, 16'h0000, 1'b0, 8'd0, 8'd255, 7'd0));
    send_item(make_dispatch(16'h0000));
  endtask

  // A worker with id zero: an unpinned dispatch reaches it once the cheaper
  // worker is full, but a pin cannot name it since zero means "any".
  task automatic test_pin_to_zero_id();
    send_item(make_update(4'd3, 16'h0000, 1'b1, 8'd0, 8'd4, 7'd90));
    send_item(make_update(4'd5, 16'h1234, 1'b1, 8'd3, 8'd4, 7'd0));
    send_item(make_dispatch(16'h0000));
    send_item(make_dispatch(16'h0000));
    send_item(make_dispatch(16'h1234));
  endtask

  // Three workers with the same id and the same score of 25: the grants go
  // to the lowest slot first, then walk upward as each score rises.
  task automatic test_tie_break();
    send_item(make_update(4'd7, 16'h00A5, 1'b1, 8'd2, 8'd10, 7'd5));
    send_item(make_update(4'd9, 16'h00A5, 1'b1, 8'd1, 8'd10, 7'd15));
    send_item(make_update(4'd12, 16'h00A5, 1'b1, 8'd2, 8'd10, 7'd5));
    send_item(make_dispatch(16'h00A5));
    send_item(make_dispatch(16'h00A5));
    send_item(make_dispatch(16'h00A5));
  endtask

  // A running worker with capacity zero can never take a task.
  task automatic test_zero_capacity();
    send_item(make_update(4'd1, 16'h7FFF, 1'b1, 8'd0, 8'd0, 7'd0));
    send_item(make_dispatch(16'h7FFF));
  endtask

  // Mixed traffic: roughly seven dispatches for every three updates.
  task automatic test_random_traffic(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      maybe_idle();
      if ($urandom_range(0, 9) < 3) begin
        send_item(random_update());
      end else begin
        send_item(random_dispatch());
      end
    end
  endtask

  // The sender holds off completely until the block has returned every
  // result, then goes straight back to traffic.
  task automatic test_drain_pause();
    wait_drain();
    test_random_traffic(100);
  endtask

  initial begin
    rst_ni = 1'b0;
    idle_cycles(RESET_CYCLES);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < SLOTS; k++) begin
      tbl_used[k]     = 1'b0;
      tbl_ident[k]    = '0;
      tbl_running[k]  = 1'b0;
      tbl_active[k]   = '0;
      tbl_capacity[k] = '0;
      tbl_load[k]     = '0;
    end

    // Directed items go back to back.
    test_empty_table();
    test_field_extremes();
    test_pin_to_zero_id();
    test_tie_break();
    test_zero_capacity();

    // Random segments alternate between bursty and continuous sending, so
    // gaps land on every cycle of a dispatch scan and there are still long
    // stretches without any.
    for (int seg = 0; seg < 5; seg++) begin
      idle_on = (seg % 2 == 0);
      test_random_traffic(280);
    end
    idle_on = 1'b1;
    test_drain_pause();

    // The last part runs without any idling.
    idle_on = 1'b0;
    test_random_traffic(300);

    wait_drain();
    if (failures == 0 && pending_grants.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
